### rtl/core/two_class_priority_queue_aging_assert.svh
// ---------------------------------------------------------------------------
// two_class_priority_queue_aging_assert
// assertion macros used by the scheduler rtl, sampled on clk_i, off in reset
// ---------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_AGING_ASSERT_SVH
`define TWO_CLASS_PRIORITY_QUEUE_AGING_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TCPQA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TCPQA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tcpqa_pkg.sv
// ---------------------------------------------------------------------------
// tcpqa_pkg
// types and constants of the two-class priority scheduler
// ---------------------------------------------------------------------------
package tcpqa_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 16;
  localparam int unsigned DEFAULT_ID_WIDTH    = 16;

  localparam int unsigned JOB_ID_W   = 16;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ELAPSED_W-1:0] WINDOW_RESET = 16'd5000;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_FULL     = 3'd1,
    ST_GRANTED  = 3'd2,
    ST_NOTHING  = 3'd3,
    ST_SHUTDOWN = 3'd4
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_ACTIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STARV_WINDOW  = 2'd1;

  typedef struct packed {
    cmd_e                cmd;
    logic [JOB_ID_W-1:0] job_id;
    logic                job_class;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [JOB_ID_W-1:0] granted_id;
    logic                granted_class;
    logic                all_empty;
  } rsp_t;

  // pointer unit control and status
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } fifo_stat_t;

endpackage

### rtl/core/tcpqa_ram.sv
// ---------------------------------------------------------------------------
// tcpqa_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module tcpqa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tcpqa_fifo_ptr.sv
// ---------------------------------------------------------------------------
// tcpqa_fifo_ptr
// head, tail and fill count of one circular job queue
// ---------------------------------------------------------------------------
module tcpqa_fifo_ptr
  import tcpqa_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fifo_ctrl_t               ctrl_i,
  output logic [$clog2(DEPTH)-1:0] head_o,
  output logic [$clog2(DEPTH)-1:0] tail_o,
  output fifo_stat_t               stat_o
);

  `include "two_class_priority_queue_aging_assert.svh"

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
    end
    if (ctrl_i.pop) begin
      head_d = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
    end
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign head_o       = head_q;
  assign tail_o       = tail_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CNT_FULL);
  assign stat_o.last  = (count_q == CNT_W'(1));

  `TCPQA_ASSERT_NOW(a_no_overrun, ctrl_i.push, count_q != CNT_FULL, "push into full queue")
  `TCPQA_ASSERT_NOW(a_no_underrun, ctrl_i.pop, count_q != '0, "pop from empty queue")
  `TCPQA_ASSERT_NOW(a_ptr_match, (count_q == '0) || (count_q == CNT_FULL), head_q == tail_q,
                    "pointers disagree with fill count")
  `TCPQA_ASSERT_NEXT(a_count_up, ctrl_i.push && !ctrl_i.pop,
                     count_q == $past(count_q) + 1'b1, "fill count missed a push")

endmodule

### rtl/core/two_class_priority_queue_aging.sv
// ---------------------------------------------------------------------------
// two_class_priority_queue_aging
// premium/free job scheduler with a starvation timer on premium runs
// ---------------------------------------------------------------------------
// usage:
//   a request (req_i) is taken on a clock edge with start high and busy
//   low. enqueue and dequeue requests give one response on rsp_o, marked by
//   rsp_valid_o for a single cycle; tick and unused commands give none.
//   an enqueue or an empty dequeue gets its response in the cycle after the
//   request; after these and a tick the next request may follow at once.
//   a granted dequeue goes through S_FETCH: the queue ram read data is
//   registered, busy is high in S_FETCH and the response is loaded there.
//   so one request is taken per cycle while busy is low.
//   the config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes system_active
//   (index 0) or starvation_window (index 1) at once; write it while idle.
//   reset empties both queues, ends any premium run, sets system_active to 1
//   and the window to 5000 ticks. the queue rams need no clearing.
//   the receiver cannot stall: each response is valid for exactly one cycle.
// ---------------------------------------------------------------------------
module two_class_priority_queue_aging
  import tcpqa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
  parameter int unsigned ID_WIDTH    = DEFAULT_ID_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  rsp_valid_o,
  output rsp_t                  rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic                 system_active_q;
  logic [ELAPSED_W-1:0] window_q;
  logic                 run_active_q, run_active_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d, elapsed_eff;

  logic pend_class_q, pend_class_d;
  logic pend_empty_q, pend_empty_d;

  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;

  fifo_ctrl_t prem_ctrl, free_ctrl;
  fifo_stat_t prem_stat, free_stat;
  logic [PTR_W-1:0] prem_head, prem_tail, free_head, free_tail;
  logic [ID_WIDTH-1:0] prem_rdata, free_rdata, wdata;

  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_q == S_FETCH);
  assign wdata  = ID_WIDTH'(req_i.job_id);

  tcpqa_fifo_ptr #(.DEPTH(QUEUE_DEPTH)) u_prem_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (prem_ctrl),
    .head_o (prem_head),
    .tail_o (prem_tail),
    .stat_o (prem_stat)
  );

  tcpqa_fifo_ptr #(.DEPTH(QUEUE_DEPTH)) u_free_ptr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (free_ctrl),
    .head_o (free_head),
    .tail_o (free_tail),
    .stat_o (free_stat)
  );

  tcpqa_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_prem_ram (
    .clk_i   (clk_i),
    .we_i    (prem_ctrl.push),
    .waddr_i (prem_tail),
    .wdata_i (wdata),
    .re_i    (prem_ctrl.pop),
    .raddr_i (prem_head),
    .rdata_o (prem_rdata)
  );

  tcpqa_ram #(.WIDTH(ID_WIDTH), .DEPTH(QUEUE_DEPTH)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (free_ctrl.push),
    .waddr_i (free_tail),
    .wdata_i (wdata),
    .re_i    (free_ctrl.pop),
    .raddr_i (free_head),
    .rdata_o (free_rdata)
  );

  // a run that is just starting sees a cleared counter
  assign elapsed_eff = run_active_q ? elapsed_q : '0;

  always_comb begin
    state_d      = state_q;
    run_active_d = run_active_q;
    elapsed_d    = elapsed_q;
    pend_class_d = pend_class_q;
    pend_empty_d = pend_empty_q;
    prem_ctrl    = '0;
    free_ctrl    = '0;
    rsp_valid_d  = 1'b0;
    rsp_d        = rsp_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.cmd)
            CMD_ENQUEUE: begin
              rsp_valid_d         = 1'b1;
              rsp_d.granted_id    = '0;
              rsp_d.granted_class = 1'b0;
              if (req_i.job_class) begin
                prem_ctrl.push  = !prem_stat.full;
                rsp_d.status    = prem_stat.full ? ST_FULL : ST_ENQUEUED;
                rsp_d.all_empty = free_stat.empty && prem_stat.full && prem_stat.empty;
              end else begin
                free_ctrl.push  = !free_stat.full;
                rsp_d.status    = free_stat.full ? ST_FULL : ST_ENQUEUED;
                rsp_d.all_empty = prem_stat.empty && free_stat.full && free_stat.empty;
              end
            end
            CMD_DEQUEUE: begin
              if (prem_stat.empty && free_stat.empty) begin
                rsp_valid_d         = 1'b1;
                rsp_d.status        = system_active_q ? ST_NOTHING : ST_SHUTDOWN;
                rsp_d.granted_id    = '0;
                rsp_d.granted_class = 1'b0;
                rsp_d.all_empty     = 1'b1;
              end else if (!prem_stat.empty) begin
                run_active_d = 1'b1;
                state_d      = S_FETCH;
                if ((elapsed_eff >= window_q) && !free_stat.empty) begin
                  free_ctrl.pop = 1'b1;
                  elapsed_d     = '0;
                  pend_class_d  = 1'b0;
                  pend_empty_d  = 1'b0;
                end else begin
                  prem_ctrl.pop = 1'b1;
                  elapsed_d     = elapsed_eff;
                  pend_class_d  = 1'b1;
                  pend_empty_d  = prem_stat.last && free_stat.empty;
                end
              end else begin
                // no premium job waits: the run ends, free head is served
                run_active_d  = 1'b0;
                free_ctrl.pop = 1'b1;
                state_d       = S_FETCH;
                pend_class_d  = 1'b0;
                pend_empty_d  = free_stat.last;
              end
            end
            CMD_TICK: begin
              if (run_active_q && (elapsed_q != '1)) begin
                elapsed_d = elapsed_q + 1'b1;
              end
            end
            CMD_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        rsp_valid_d         = 1'b1;
        rsp_d.status        = ST_GRANTED;
        rsp_d.granted_id    = pend_class_q ? JOB_ID_W'(prem_rdata) : JOB_ID_W'(free_rdata);
        rsp_d.granted_class = pend_class_q;
        rsp_d.all_empty     = pend_empty_q;
        state_d             = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      run_active_q    <= 1'b0;
      elapsed_q       <= '0;
      rsp_valid_q     <= 1'b0;
      system_active_q <= 1'b1;
      window_q        <= WINDOW_RESET;
    end else begin
      state_q      <= state_d;
      run_active_q <= run_active_d;
      elapsed_q    <= elapsed_d;
      rsp_valid_q  <= rsp_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SYSTEM_ACTIVE) begin
          system_active_q <= cfg_data_i[0];
        end else if (cfg_idx_i == REG_STARV_WINDOW) begin
          window_q <= ELAPSED_W'(cfg_data_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q        <= rsp_d;
    pend_class_q <= pend_class_d;
    pend_empty_q <= pend_empty_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// two-class scheduler with starvation timer: a queue-fed driver offers
// enqueue, dequeue, tick and unused requests with random gaps. A queue
// model predicts each response, and a monitor checks every field in order.
// Runs several register settings, the window extremes among them.
// ---------------------------------------------------------------------------
module testbench;
  import tcpqa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  req_t                  req_i = '0;
  logic                  rsp_valid_o;
  rsp_t                  rsp_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  two_class_priority_queue_aging dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // scheduler model state
  logic [JOB_ID_W-1:0]  premium_jobs[$];
  logic [JOB_ID_W-1:0]  free_jobs[$];
  logic                 run_active = 1'b0;
  logic [ELAPSED_W-1:0] run_ticks = '0;
  logic                 sys_active = 1'b1;
  logic [ELAPSED_W-1:0] starv_window = WINDOW_RESET;

  req_t        pending_req[$];
  rsp_t        awaited_rsp[$];
  int unsigned unaccepted = 0;
  int unsigned idle_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  task automatic predict_response(input req_t r);
    rsp_t o;
    logic has_rsp;
    o = '0;
    has_rsp = 1'b1;
    case (r.cmd)
      CMD_TICK: begin
        has_rsp = 1'b0;
        if (run_active && run_ticks != ELAPSED_MAX) run_ticks = run_ticks + 1'b1;
      end
      CMD_ENQUEUE: begin
        o.status = ST_FULL;
        if (r.job_class) begin
          if (premium_jobs.size() < DEFAULT_QUEUE_DEPTH) begin
            premium_jobs.push_back(r.job_id);
            o.status = ST_ENQUEUED;
          end
        end else if (free_jobs.size() < DEFAULT_QUEUE_DEPTH) begin
          free_jobs.push_back(r.job_id);
          o.status = ST_ENQUEUED;
        end
      end
      CMD_DEQUEUE: begin
        if (premium_jobs.size() == 0 && free_jobs.size() == 0) begin
          if (sys_active) o.status = ST_NOTHING;
          else o.status = ST_SHUTDOWN;
        end else if (premium_jobs.size() != 0) begin
          if (!run_active) begin
            run_active = 1'b1;
            run_ticks = '0;
          end
          o.status = ST_GRANTED;
          // starved free job jumps the premium line once per window
          if (run_ticks >= starv_window && free_jobs.size() != 0) begin
            o.granted_id = free_jobs.pop_front();
            run_ticks = '0;
          end else begin
            o.granted_id = premium_jobs.pop_front();
            o.granted_class = 1'b1;
          end
        end else begin
          run_active = 1'b0;
          o.status = ST_GRANTED;
          o.granted_id = free_jobs.pop_front();
        end
      end
      default: has_rsp = 1'b0;
    endcase
    o.all_empty = (premium_jobs.size() == 0 && free_jobs.size() == 0);
    if (has_rsp) awaited_rsp.push_back(o);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_response(req_i);
        unaccepted--;
      end
      if (!start || !busy) begin
        if (pending_req.size() != 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          req_i <= pending_req.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (awaited_rsp.size() == 0) begin
        $error("response with none awaited: status %0d, id %0h", rsp_o.status,
               rsp_o.granted_id);
        errors++;
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.granted_id !== want.granted_id) begin
          $error("granted_id: expected %0h, got %0h", want.granted_id, rsp_o.granted_id);
          errors++;
        end
        if (rsp_o.granted_class !== want.granted_class) begin
          $error("granted_class: expected %0d, got %0d", want.granted_class,
                 rsp_o.granted_class);
          errors++;
        end
        if (rsp_o.all_empty !== want.all_empty) begin
          $error("all_empty: expected %0d, got %0d", want.all_empty, rsp_o.all_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_req(input cmd_e cmd, input logic [JOB_ID_W-1:0] id, input logic cls);
    req_t r;
    r.cmd = cmd;
    r.job_id = id;
    r.job_class = cls;
    pending_req.push_back(r);
    unaccepted++;
  endtask

  // every request taken and answered, then idle clocks for trailing ticks
  task automatic wait_idle();
    @(posedge clk_i);
    while (unaccepted != 0 || awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SYSTEM_ACTIVE) sys_active = val[0];
    else if (idx == REG_STARV_WINDOW) starv_window = val;
  endtask

  // bursts that lean toward filling, draining or a mix, so both full and
  // empty queues come up often
  task automatic add_random(input int unsigned n);
    int unsigned mode;
    int unsigned left;
    int unsigned enq_lim;
    int unsigned deq_lim;
    int unsigned tick_lim;
    int unsigned pick;
    left = 0;
    mode = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (left == 0) begin
        mode = $urandom_range(2);
        left = $urandom_range(40, 10);
      end
      left--;
      case (mode)
        0:       begin enq_lim = 65; deq_lim = 85; tick_lim = 97; end
        1:       begin enq_lim = 20; deq_lim = 80; tick_lim = 97; end
        default: begin enq_lim = 40; deq_lim = 75; tick_lim = 96; end
      endcase
      pick = $urandom_range(99);
      if (pick < enq_lim) begin
        add_req(CMD_ENQUEUE, JOB_ID_W'($urandom), 1'($urandom_range(1)));
      end else if (pick < deq_lim) begin
        add_req(CMD_DEQUEUE, JOB_ID_W'($urandom), 1'($urandom_range(1)));
      end else if (pick < tick_lim) begin
        add_req(CMD_TICK, JOB_ID_W'($urandom), 1'($urandom_range(1)));
      end else begin
        add_req(CMD_NONE, JOB_ID_W'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_phase(input logic active, input logic [ELAPSED_W-1:0] window,
                           input int unsigned gap_pct, input int unsigned n);
    wait_idle();
    write_reg(REG_SYSTEM_ACTIVE, CFG_DATA_W'(($urandom & 32'hFFFE) | active));
    write_reg(REG_STARV_WINDOW, window);
    idle_pct = gap_pct;
    add_random(n);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty dequeue, tick with no run, unused command,
    // premium before free, run ends on a free grant, premium queue overflow
    add_req(CMD_DEQUEUE, 16'h0000, 1'b0);
    add_req(CMD_TICK, 16'hFFFF, 1'b1);
    add_req(CMD_NONE, 16'hFFFF, 1'b1);
    add_req(CMD_ENQUEUE, 16'h0000, 1'b0);
    add_req(CMD_ENQUEUE, 16'hFFFF, 1'b1);
    add_req(CMD_DEQUEUE, 16'h0000, 1'b0);
    add_req(CMD_DEQUEUE, 16'hFFFF, 1'b1);
    add_req(CMD_DEQUEUE, 16'h0000, 1'b0);
    for (int unsigned i = 0; i <= DEFAULT_QUEUE_DEPTH; i++) begin
      add_req(CMD_ENQUEUE, JOB_ID_W'((i % 2) ? 32'hAAAA ^ i : 32'h5555 ^ i), 1'b1);
    end

    // zero window: a waiting free job goes first as soon as a run starts
    run_phase(1'b1, 16'd0, 0, 0);
    add_req(CMD_ENQUEUE, 16'h0F0F, 1'b0);
    add_req(CMD_DEQUEUE, 16'h0000, 1'b0);
    add_random(250);

    wait_idle();
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    run_phase(1'b0, 16'd3, 51, 250);
    run_phase(1'b1, 16'd1, 0, 250);

    // widest window: premium keeps priority until its queue drains, then
    // the free job is served
    run_phase(1'b1, 16'hFFFF, 27, 0);
    repeat (2 * DEFAULT_QUEUE_DEPTH + 4) begin
      add_req(CMD_DEQUEUE, JOB_ID_W'($urandom), 1'($urandom_range(1)));
    end
    add_req(CMD_ENQUEUE, JOB_ID_W'($urandom), 1'b1);
    add_req(CMD_ENQUEUE, JOB_ID_W'($urandom), 1'b1);
    add_req(CMD_ENQUEUE, JOB_ID_W'($urandom), 1'b0);
    add_req(CMD_DEQUEUE, JOB_ID_W'($urandom), 1'b0);
    repeat (60) add_req(CMD_TICK, JOB_ID_W'($urandom), 1'($urandom_range(1)));
    add_req(CMD_DEQUEUE, JOB_ID_W'($urandom), 1'b0);
    add_req(CMD_DEQUEUE, JOB_ID_W'($urandom), 1'b0);
    add_random(50);

    run_phase(1'b0, 16'd7, 27, 250);
    run_phase(1'b1, ELAPSED_W'($urandom_range(20)), 51, 250);
    run_phase(1'b1, WINDOW_RESET, 0, 100);

    wait_idle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
